@@ hw/rtl/swap_slot_bitmap_allocator_defines.svh @@
// Assertion macros used by the swap slot allocator controller RTL.
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while in reset.
`define SSBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property, also active during reset.
`define SSBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SSBA_ASSERT(lbl, prop, msg)
`define SSBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/ssba_pkg.sv @@
// Shared types, codes and helpers for the swap slot bitmap allocator.
package ssba_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 1024;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned FREE_W        = 11;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned BIT_W         = 6;

  // Request operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAME   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_left;
  } rsp_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic clear;  // zero one bitmap word, advance sweep pointer
    logic latch;  // capture request beat
    logic look;   // pick word, issue bitmap read
    logic exec;   // update state, load response register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clear_done;
  } sts_t;

  // Index of the lowest set bit; zero when none set.
  function automatic logic [BIT_W-1:0] lowest_one(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/ssba_ctrl.sv @@
// Sequencing FSM for the swap slot allocator: clear sweep, accept, look, execute.
`include "swap_slot_bitmap_allocator_defines.svh"

module ssba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssba_pkg::cmd_t cmd_o,
  input  ssba_pkg::sts_t sts_i
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       exec_go;

  // Execute only when the response register is free or draining this cycle.
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_done) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_LOOK;
      S_LOOK:  state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (exec_go)     out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.clear = (state_q == S_CLEAR);
  assign cmd_o.latch = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.look  = (state_q == S_LOOK);
  assign cmd_o.exec  = exec_go;
  assign out_valid_o = out_valid_q;

  `SSBA_ASSERT(a_exec_gives_beat, exec_go |=> out_valid_q, "execute did not post a response")
  `SSBA_ASSERT(a_look_then_exec, state_q == S_LOOK |=> state_q == S_EXEC, "no exec after look")
  `SSBA_ASSERT(a_clear_ends, cmd_o.clear && sts_i.clear_done |=> in_ready_o, "clear sweep stuck")

endmodule

@@ hw/rtl/ssba_dp.sv @@
// Datapath: bitmap memory, full-word summary, free counter, response register.
module ssba_dp #(
  parameter int unsigned NUM_SLOTS = ssba_pkg::NUM_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssba_pkg::req_t in_req_i,
  output ssba_pkg::rsp_t out_rsp_o,
  input  ssba_pkg::cmd_t cmd_i,
  output ssba_pkg::sts_t sts_o
);

  localparam int unsigned WORD_W = ssba_pkg::WORD_W;
  localparam int unsigned WORDS  = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned WIDX   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned REM    = NUM_SLOTS % WORD_W;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);

  // Bits past the last slot never count toward a word being full.
  function automatic logic [WORD_W-1:0] vmask(logic [WIDX-1:0] w);
    logic [WORD_W-1:0] m;
    m = '1;
    if (REM != 0 && w == WIDX'(WORDS - 1)) m = (WORD_W'(1) << REM) - WORD_W'(1);
    return m;
  endfunction

  ssba_pkg::req_t     req_q;
  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORD_W-1:0]  rdata_q;
  logic [WORDS-1:0]   full_q, full_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [WIDX-1:0]    clr_q;
  logic [WIDX-1:0]    word_q;
  logic               hit_q;
  ssba_pkg::rsp_t     rsp_q, rsp_d;

  logic [WIDX-1:0]    ff_word, slot_word, rd_addr, waddr;
  logic               ff_found;
  logic [31:0]        slot_ext;
  logic               we, chg;
  logic [WORD_W-1:0]  wdata, upd_word, avail;
  logic [ssba_pkg::BIT_W-1:0] pick;
  logic [31:0]        alloc_slot;
  logic               in_range, used;

  // Lowest word whose summary bit is clear.
  always_comb begin
    ff_found = 1'b0;
    ff_word  = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        ff_found = 1'b1;
        ff_word  = WIDX'(i);
      end
    end
  end

  assign slot_ext  = 32'(req_q.slot);
  assign slot_word = WIDX'(slot_ext >> 6);
  assign rd_addr   = (req_q.func == ssba_pkg::FUNC_ALLOC) ? ff_word : slot_word;
  assign in_range  = slot_ext < 32'(NUM_SLOTS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) req_q <= in_req_i;
    if (cmd_i.look) begin
      word_q  <= rd_addr;
      hit_q   <= ff_found && (cnt_q != '0);
      rdata_q <= mem[rd_addr];
    end
    if (we) mem[waddr] <= wdata;
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      full_q <= '0;
      cnt_q  <= CNT_W'(NUM_SLOTS);
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + WIDX'(1);
      full_q <= full_d;
      cnt_q  <= cnt_d;
    end
  end

  assign sts_o.clear_done = (clr_q == WIDX'(WORDS - 1));

  // Execute step: modify the word read in the look step.
  always_comb begin
    avail      = ~rdata_q & vmask(word_q);
    pick       = ssba_pkg::lowest_one(avail);
    alloc_slot = (32'(word_q) << 6) | 32'(pick);
    used       = rdata_q[req_q.slot[ssba_pkg::BIT_W-1:0]];
    upd_word   = rdata_q;
    chg        = 1'b0;
    cnt_d      = cnt_q;
    rsp_d.slot_out = req_q.slot;
    rsp_d.status   = ssba_pkg::ST_OK;
    case (req_q.func)
      ssba_pkg::FUNC_ALLOC: begin
        if (hit_q) begin
          upd_word[pick] = 1'b1;
          chg            = 1'b1;
          cnt_d          = cnt_q - CNT_W'(1);
          rsp_d.slot_out = alloc_slot[ssba_pkg::SLOT_W-1:0];
        end else begin
          rsp_d.slot_out = '0;
          rsp_d.status   = ssba_pkg::ST_NOFREE;
        end
      end
      ssba_pkg::FUNC_MARK: begin
        if (!in_range) rsp_d.status = ssba_pkg::ST_RANGE;
        else if (used) rsp_d.status = ssba_pkg::ST_SAME;
        else begin
          upd_word[req_q.slot[ssba_pkg::BIT_W-1:0]] = 1'b1;
          chg   = 1'b1;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ssba_pkg::FUNC_RELEASE: begin
        if (!in_range) rsp_d.status = ssba_pkg::ST_RANGE;
        else if (!used) rsp_d.status = ssba_pkg::ST_SAME;
        else begin
          upd_word[req_q.slot[ssba_pkg::BIT_W-1:0]] = 1'b0;
          chg   = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: ;  // no operation
    endcase
    if (!cmd_i.exec) begin
      chg   = 1'b0;
      cnt_d = cnt_q;
    end
    rsp_d.free_left = ssba_pkg::FREE_W'(32'(cnt_d));
  end

  always_comb begin
    full_d = full_q;
    if (chg) full_d[word_q] = &(upd_word | ~vmask(word_q));
  end

  assign we    = cmd_i.clear || chg;
  assign waddr = cmd_i.clear ? clr_q : word_q;
  assign wdata = cmd_i.clear ? '0 : upd_word;

  assign out_rsp_o = rsp_q;

endmodule

@@ hw/rtl/swap_slot_bitmap_allocator.sv @@
// Top level of the swap slot bitmap allocator: controller plus datapath.
//
//   beat      dir  handshake                 payload
//   request   in   in_valid_i / in_ready_o   in_req_i  (func, slot)
//   response  out  out_valid_o / out_ready_i out_rsp_o (slot_out, status, free_left)
//
// Each request passes through accept, look (pick the lowest non-full word from the
//   summary vector for an allocate, else the named slot's word, and read it) and
//   execute (set or clear one bit, for an allocate the lowest clear bit, write back).
// One request at a time. After reset a clearing pass zeroes the bitmap, one word per
//   cycle from word 0 up to the last word, during which no request is accepted.
// The response register lets a new request enter while the last beat waits;
//   a stalled response holds the next request in its execute step.
module swap_slot_bitmap_allocator #(
  parameter int unsigned NUM_SLOTS = ssba_pkg::NUM_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssba_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssba_pkg::rsp_t out_rsp_o
);

  ssba_pkg::cmd_t cmd;
  ssba_pkg::sts_t sts;

  // Sequencer: owns the handshakes and the response valid flag.
  ssba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Bitmap, summary, free count and response payload.
  ssba_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

@@ dv/swap_slot_bitmap_allocator_test.sv @@
// Testbench for swap_slot_bitmap_allocator: random valid/ready traffic against a slot ledger.
module swap_slot_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = ssba_pkg::NUM_SLOTS_DEF;
  localparam int unsigned WORDS = (SLOTS + ssba_pkg::WORD_W - 1) / ssba_pkg::WORD_W;
  // Slowest correct run: 850 beats, each with the longest request-side idle
  // gap, its pass through the block and the longest response-side stall,
  // plus the clearing pass; allow well over ten times that.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BEATS = 828;

  // Ledger of slot ownership: mirrors the bitmap, the per-word full flags and
  // the free count, and holds the responses still owed by the block.
  class slot_ledger;
    logic [ssba_pkg::WORD_W-1:0] map_q [WORDS];
    logic [WORDS-1:0]            full_q;
    logic [ssba_pkg::FREE_W-1:0] free_q;
    ssba_pkg::rsp_t              owed_rsp[$];
    int                          errors;
    int                          req_seen;
    int                          rsp_seen;
    int                          func_seen [4];
    int                          status_seen [4];
    int                          nofree_hits;
    int                          free_low;

    function void clear();
      foreach (map_q[w]) map_q[w] = '0;
      full_q = '0;
      free_q = ssba_pkg::FREE_W'(SLOTS);
      free_low = int'(SLOTS);
    endfunction

    // Valid bits of word w; only the last word can be partly valid.
    function logic [ssba_pkg::WORD_W-1:0] word_mask(int w);
      if ((w + 1) * ssba_pkg::WORD_W <= SLOTS) return '1;
      return (64'd1 << (SLOTS % ssba_pkg::WORD_W)) - 64'd1;
    endfunction

    function void refresh_full(int w);
      full_q[w] = ((map_q[w] & word_mask(w)) == word_mask(w));
    endfunction

    function logic is_used(logic [ssba_pkg::SLOT_W-1:0] s);
      if (int'(s) >= SLOTS) return 1'b0;
      return map_q[s / ssba_pkg::WORD_W][s % ssba_pkg::WORD_W];
    endfunction

    // Apply one request to the ledger and return the response it owes.
    function ssba_pkg::rsp_t apply_request(ssba_pkg::req_t r);
      ssba_pkg::rsp_t              p;
      logic [ssba_pkg::WORD_W-1:0] avail;
      logic                        found;
      logic                        used;
      int                          w;
      p.slot_out = r.slot;
      p.status = ssba_pkg::ST_OK;
      found = 1'b0;
      case (r.func)
        ssba_pkg::FUNC_ALLOC: begin
          p.slot_out = '0;
          p.status = ssba_pkg::ST_NOFREE;
          if (free_q != 0) begin
            for (int wi = 0; wi < WORDS; wi++) begin
              if (!found && !full_q[wi]) begin
                avail = ~map_q[wi] & word_mask(wi);
                for (int b = 0; b < ssba_pkg::WORD_W; b++) begin
                  if (!found && avail[b]) begin
                    map_q[wi][b] = 1'b1;
                    refresh_full(wi);
                    free_q = free_q - 1'b1;
                    p.slot_out = ssba_pkg::SLOT_W'(wi * ssba_pkg::WORD_W + b);
                    p.status = ssba_pkg::ST_OK;
                    found = 1'b1;
                  end
                end
              end
            end
          end
          if (!found) nofree_hits++;
        end
        ssba_pkg::FUNC_MARK, ssba_pkg::FUNC_RELEASE: begin
          if (int'(r.slot) >= SLOTS) begin
            p.status = ssba_pkg::ST_RANGE;
          end else begin
            w = r.slot / ssba_pkg::WORD_W;
            used = map_q[w][r.slot % ssba_pkg::WORD_W];
            if (r.func == ssba_pkg::FUNC_MARK) begin
              if (used) begin
                p.status = ssba_pkg::ST_SAME;
              end else begin
                map_q[w][r.slot % ssba_pkg::WORD_W] = 1'b1;
                free_q = free_q - 1'b1;
              end
            end else begin
              if (!used) begin
                p.status = ssba_pkg::ST_SAME;
              end else begin
                map_q[w][r.slot % ssba_pkg::WORD_W] = 1'b0;
                free_q = free_q + 1'b1;
              end
            end
            refresh_full(w);
          end
        end
        default: ;  // no operation: named slot echoed, state untouched
      endcase
      p.free_left = free_q;
      return p;
    endfunction

    function void note_request(ssba_pkg::req_t r);
      req_seen++;
      func_seen[r.func]++;
      owed_rsp.push_back(apply_request(r));
      if (int'(free_q) < free_low) free_low = int'(free_q);
    endfunction

    function void check_response(ssba_pkg::rsp_t got);
      ssba_pkg::rsp_t want;
      rsp_seen++;
      status_seen[got.status]++;
      if (owed_rsp.size() == 0) begin
        errors++;
        $display("%0t: response beat with nothing outstanding: expected none, got %0d/%0d/%0d",
                 $time, got.slot_out, got.status, got.free_left);
        return;
      end
      want = owed_rsp.pop_front();
      if (got.slot_out !== want.slot_out) begin
        errors++;
        $display("%0t: slot_out expected %0d, got %0d", $time, want.slot_out, got.slot_out);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.free_left !== want.free_left) begin
        errors++;
        $display("%0t: free_left expected %0d, got %0d", $time, want.free_left, got.free_left);
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  ssba_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_ready_i;
  ssba_pkg::rsp_t out_rsp_o;

  slot_ledger sb;
  int         cycle_cnt;
  int         in_calm;   // remaining beats sent back to back
  int         out_calm;  // remaining beats taken without stall

  swap_slot_bitmap_allocator #(
    .NUM_SLOTS(SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    cycle_cnt = 0;
    in_calm = 0;
    out_calm = 0;
    sb = new;
    sb.clear();
  end

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, sb.owed_rsp.size());
      $display("swap_slot_bitmap_allocator verification failed");
      $finish;
    end
  end

  // Idle draw per beat: mostly a uniform random gap, with occasional back-to-back runs.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Random slot, steered toward one that is used (or free) in the ledger.
  function automatic logic [ssba_pkg::SLOT_W-1:0] pick_slot(logic want_used);
    logic [ssba_pkg::SLOT_W-1:0] s;
    s = ssba_pkg::SLOT_W'($urandom_range(0, 1023));
    for (int i = 0; i < 32; i++) begin
      if (sb.is_used(s) == want_used) return s;
      s = ssba_pkg::SLOT_W'($urandom_range(0, 1023));
    end
    return s;
  endfunction

  // Present one request beat and hold it until accepted. Valid stays high
  // afterwards so a zero-gap next beat never drops it within the same step.
  task automatic send_req(input logic [ssba_pkg::FUNC_W-1:0] f,
                          input logic [ssba_pkg::SLOT_W-1:0] s);
    ssba_pkg::req_t r;
    int             gap;
    r.func = f;
    r.slot = s;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // Random beat from a weighted mix (percent thresholds for alloc, mark,
  // release; the rest is no-op). Mark and release mostly hit slots whose
  // state lets them succeed, so the map really fills and drains.
  task automatic send_mixed(input int p_alloc, input int p_mark, input int p_rel);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < p_alloc)
      send_req(ssba_pkg::FUNC_ALLOC, ssba_pkg::SLOT_W'($urandom_range(0, 1023)));
    else if (roll < p_alloc + p_mark)
      send_req(ssba_pkg::FUNC_MARK, pick_slot($urandom_range(0, 3) == 0));
    else if (roll < p_alloc + p_mark + p_rel)
      send_req(ssba_pkg::FUNC_RELEASE, pick_slot($urandom_range(0, 4) != 0));
    else
      send_req(ssba_pkg::FUNC_NOP, ssba_pkg::SLOT_W'($urandom_range(0, 1023)));
  endtask

  // Response side: ready held high until a beat is taken, then a fresh stall.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_response(out_rsp_o);
    end
  end

  initial begin
    int rnd_beats;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lowest-free order, word boundaries, top slot, double mark,
    // double release, refill of a freed hole, and no-ops at field extremes.
    // A slot beyond the map is not reachable here: the 10-bit field tops
    // out at the last slot of a 1024-slot map.
    send_req(ssba_pkg::FUNC_ALLOC, 10'h3FF);     // slot 0
    send_req(ssba_pkg::FUNC_ALLOC, 10'h000);     // slot 1
    send_req(ssba_pkg::FUNC_MARK, 10'd0);        // already used
    send_req(ssba_pkg::FUNC_MARK, 10'd1023);     // top slot
    send_req(ssba_pkg::FUNC_MARK, 10'd1023);     // already used
    send_req(ssba_pkg::FUNC_RELEASE, 10'd1023);
    send_req(ssba_pkg::FUNC_RELEASE, 10'd1023);  // already free
    send_req(ssba_pkg::FUNC_RELEASE, 10'd5);     // never used
    send_req(ssba_pkg::FUNC_RELEASE, 10'd0);
    send_req(ssba_pkg::FUNC_ALLOC, 10'h2AA);     // refills slot 0
    send_req(ssba_pkg::FUNC_ALLOC, 10'h155);     // slot 2
    send_req(ssba_pkg::FUNC_MARK, 10'd63);       // last bit of word 0
    send_req(ssba_pkg::FUNC_MARK, 10'd64);       // first bit of word 1
    send_req(ssba_pkg::FUNC_MARK, 10'h2AA);
    send_req(ssba_pkg::FUNC_MARK, 10'h155);
    send_req(ssba_pkg::FUNC_NOP, 10'h3FF);
    send_req(ssba_pkg::FUNC_NOP, 10'h000);
    send_req(ssba_pkg::FUNC_NOP, 10'h2AA);
    send_req(ssba_pkg::FUNC_RELEASE, 10'h155);
    send_req(ssba_pkg::FUNC_ALLOC, 10'h3FF);     // slot 3
    send_req(ssba_pkg::FUNC_RELEASE, 10'd64);
    send_req(ssba_pkg::FUNC_RELEASE, 10'd63);

    // Churn: balanced mix around a lightly used map.
    rnd_beats = 0;
    repeat (150) begin
      send_mixed(35, 20, 35);
      rnd_beats++;
    end
    // Fill: allocation-heavy, pushing the search up through the words; ends
    // early should the map run dry a dozen times.
    while (sb.nofree_hits < 12 && rnd_beats < RANDOM_BEATS - 200) begin
      send_mixed(80, 8, 6);
      rnd_beats++;
    end
    // Drain: release-heavy back down.
    while (rnd_beats < RANDOM_BEATS) begin
      send_mixed(20, 15, 55);
      rnd_beats++;
    end
    in_valid_i <= 1'b0;

    while (sb.owed_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d requests (alloc %0d, mark %0d, release %0d, no-op %0d), %0d responses checked",
             sb.req_seen, sb.func_seen[ssba_pkg::FUNC_ALLOC],
             sb.func_seen[ssba_pkg::FUNC_MARK], sb.func_seen[ssba_pkg::FUNC_RELEASE],
             sb.func_seen[ssba_pkg::FUNC_NOP], sb.rsp_seen);
    $display("status ok %0d, no free %0d, range %0d, same state %0d; free count fell to %0d",
             sb.status_seen[ssba_pkg::ST_OK], sb.status_seen[ssba_pkg::ST_NOFREE],
             sb.status_seen[ssba_pkg::ST_RANGE], sb.status_seen[ssba_pkg::ST_SAME],
             sb.free_low);
    if (sb.owed_rsp.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d responses never arrived", $time, sb.owed_rsp.size());
    end
    if (sb.errors == 0) begin
      $display("swap_slot_bitmap_allocator verification clean");
    end else begin
      $display("swap_slot_bitmap_allocator verification failed");
    end
    $finish;
  end

endmodule
